// File: rtl/assert_macros.svh
// Assertion macros shared by the cipher RTL.
// Every use assumes clk and rst_n are visible in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication or expression on every clock edge outside reset.
`define PBFSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checks that a condition in one cycle leads to another in the next cycle.
`define PBFSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pbfsc_pkg.sv
// Shared types and constants for the packet byte feedback stream cipher.
// No dependencies; used by the controller, the datapath and the top level.
package pbfsc_pkg;

  localparam int KEY_LEN    = 10;
  localparam int ROUNDS     = 5;
  localparam int ROUND_W    = $clog2(ROUNDS);

  localparam logic [31:0] MUL_A = 32'h0000_4E35;
  localparam logic [31:0] MUL_C = 32'h0000_015A;

  localparam logic [ROUND_W-1:0] ROUND_FIRST = '0;
  localparam logic [ROUND_W-1:0] ROUND_LAST  = ROUND_W'(ROUNDS - 1);

  typedef logic [KEY_LEN-1:0][7:0] key_t;

  // Index 0 is the first key byte.
  localparam key_t START_KEY = {8'h21, 8'h73, 8'h65, 8'h6c, 8'h75,
                                8'h52, 8'h79, 8'h62, 8'h6c, 8'h41};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic               load;
    logic               round_en;
    logic [ROUND_W-1:0] round_idx;
    logic               finish;
  } dp_cmd_t;

  typedef struct packed {
    logic first;
  } dp_sts_t;

endpackage

// File: rtl/pbfsc_dp.sv
// Datapath of the cipher: captured beat, generator words, key store,
// shared round unit and output register. Depends on pbfsc_pkg.
module pbfsc_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  pbfsc_pkg::dp_cmd_t cmd,
  output pbfsc_pkg::dp_sts_t sts,
  input  logic [7:0]        in_data_byte,
  input  logic              in_first_of_packet,
  input  logic              in_op,
  output logic [7:0]        out_byte
);
  import pbfsc_pkg::*;

  logic [31:0] sum_r, sum_nxt;
  logic [31:0] cross_r, cross_nxt;
  logic [31:0] prev_r, prev_nxt;
  logic [15:0] acc_r, acc_nxt;
  key_t        key_r, key_nxt;
  logic [7:0]  data_r;
  logic        first_r;
  logic        op_r;
  logic [7:0]  out_byte_r;

  logic [31:0] pair;
  logic [31:0] w;
  logic [31:0] c;
  logic [31:0] s;
  logic [31:0] nw;
  logic [7:0]  res;
  logic [7:0]  fb;

  // One generator round per cycle.
  always_comb begin
    pair = {16'h0000, key_r[0], key_r[1]};
    w    = (cmd.round_idx == ROUND_FIRST) ? pair : (pair ^ prev_r);
    c    = w * MUL_C;
    s    = cross_r + (sum_r + 32'(cmd.round_idx)) * MUL_A + c;
    nw   = w * MUL_A + 32'h0000_0001;
    res  = data_r ^ acc_r[7:0] ^ acc_r[15:8];
    fb   = op_r ? res : data_r;
  end

  always_comb begin
    sum_nxt   = sum_r;
    cross_nxt = cross_r;
    prev_nxt  = prev_r;
    acc_nxt   = acc_r;
    key_nxt   = key_r;
    if (cmd.load) begin
      acc_nxt = '0;
    end
    if (cmd.round_en) begin
      sum_nxt   = s;
      cross_nxt = c;
      prev_nxt  = nw;
      acc_nxt   = acc_r ^ s[15:0] ^ nw[15:0];
      // Rotating by one pair puts the next round's bytes at the front; after
      // all rounds the store is back in its original order.
      for (int i = 0; i < KEY_LEN; i++) begin
        key_nxt[i] = key_r[(i + 2) % KEY_LEN];
      end
    end
    if (cmd.finish) begin
      if (first_r) begin
        sum_nxt   = '0;
        cross_nxt = '0;
        key_nxt   = START_KEY;
      end else begin
        for (int i = 0; i < KEY_LEN; i++) begin
          key_nxt[i] = key_r[i] ^ fb;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      cross_r <= '0;
      key_r   <= START_KEY;
    end else begin
      sum_r   <= sum_nxt;
      cross_r <= cross_nxt;
      key_r   <= key_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r <= prev_nxt;
    acc_r  <= acc_nxt;
    if (cmd.load) begin
      data_r  <= in_data_byte;
      first_r <= in_first_of_packet;
      op_r    <= in_op;
    end
    if (cmd.finish) begin
      out_byte_r <= first_r ? data_r : res;
    end
  end

  assign sts.first = first_r;
  assign out_byte  = out_byte_r;

endmodule

// File: rtl/pbfsc_ctrl.sv
// Controller of the cipher: sequences load, five rounds and the finish step,
// and owns both handshakes. Depends on pbfsc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pbfsc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output pbfsc_pkg::dp_cmd_t cmd,
  input  pbfsc_pkg::dp_sts_t sts
);
  import pbfsc_pkg::*;

  state_t             state_r, state_nxt;
  logic [ROUND_W-1:0] round_r, round_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               slot_free;

  assign slot_free = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    case (state_r)
      ST_IDLE: begin
        round_nxt = ROUND_FIRST;
        if (in_valid) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        // A flag beat skips the rounds and only restarts the state.
        if (sts.first || round_r == ROUND_LAST) begin
          state_nxt = ST_FINISH;
        end else begin
          round_nxt = round_r + 1'b1;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.round_idx = round_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_ROUND: begin
        cmd.round_en = !sts.first;
      end
      ST_FINISH: begin
        cmd.finish = slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      round_r     <= ROUND_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `PBFSC_ASSERT(a_round_range, round_r <= ROUND_LAST, "round counter out of range")
  `PBFSC_ASSERT(a_finish_free, cmd.finish |-> slot_free, "result written over a held beat")
  `PBFSC_ASSERT_NEXT(a_finish_valid, cmd.finish, out_valid_r, "finished result not presented")
  `PBFSC_ASSERT_NEXT(a_accept_round, in_valid && in_ready, state_r == ST_ROUND,
                     "accepted beat did not start rounds")

endmodule

// File: rtl/packet_byte_feedback_stream_cipher.sv
// Packet byte feedback stream cipher, top level. Depends on pbfsc_pkg,
// pbfsc_ctrl and pbfsc_dp.
//
// One byte per beat in, one byte per beat out. A beat flagged as first of
// packet passes through unchanged and returns the generator words and key
// to their starting values. It passes the round state without a round, its
// result is registered in the finish step, and the next beat can be
// accepted only after that step. Every other beat runs five generator
// rounds on one shared round unit, one round per clock. Its result is
// registered in the finish step after the last round, and no new beat is
// accepted before that step. The result sits in an output register, so the
// next beat can be accepted while it waits. A beat whose rounds are done
// holds in its finish step while the previous result has not been taken.
module packet_byte_feedback_stream_cipher (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_first_of_packet,
  input  logic       in_op,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte
);
  import pbfsc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  pbfsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  pbfsc_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_data_byte       (in_data_byte),
    .in_first_of_packet (in_first_of_packet),
    .in_op              (in_op),
    .out_byte           (out_byte)
  );

endmodule
